### rtl/core/ctsh_pkg.sv
`timescale 1ns / 1ps

package ctsh_pkg;

  // field widths
  localparam int unsigned HourW    = 5;
  localparam int unsigned MinW     = 6;
  localparam int unsigned SecW     = 6;
  localparam int unsigned DebW     = 8;
  localparam int unsigned CntW     = 16;
  localparam int unsigned StepW    = 6;
  localparam int unsigned DeltaW   = 7;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  // time limits
  localparam logic [HourW-1:0] MaxHour = HourW'(23);
  localparam logic [MinW-1:0]  MaxMin  = MinW'(59);
  localparam logic [SecW-1:0]  MaxSec  = SecW'(59);

  // configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_DEBOUNCE = 3'd0,
    CFG_MEDIUM   = 3'd1,
    CFG_FAST     = 3'd2,
    CFG_REPEAT   = 3'd3,
    CFG_FSTEP    = 3'd4,
    CFG_IDLE     = 3'd5
  } cfg_idx_t;

  // configuration reset values
  localparam logic [DebW-1:0]  DebounceRst = DebW'(50);
  localparam logic [CntW-1:0]  MediumRst   = CntW'(500);
  localparam logic [CntW-1:0]  FastRst     = CntW'(2000);
  localparam logic [CntW-1:0]  RepeatRst   = CntW'(250);
  localparam logic [StepW-1:0] FstepRst    = StepW'(5);
  localparam logic [CntW-1:0]  IdleRst     = CntW'(5000);

  // held button codes
  typedef enum logic [1:0] {
    HELD_NONE = 2'd0,
    HELD_UP   = 2'd1,
    HELD_DOWN = 2'd2
  } held_t;

  typedef struct packed {
    logic [DebW-1:0]  debounce_ticks;
    logic [CntW-1:0]  medium_after;
    logic [CntW-1:0]  fast_after;
    logic [CntW-1:0]  repeat_ticks;
    logic [StepW-1:0] fast_step;
    logic [CntW-1:0]  idle_exit;
  } cfg_t;

  typedef struct packed {
    logic             tick;
    logic             up_edge;
    logic             down_edge;
    logic             up_level;
    logic             down_level;
    logic             rtc_valid;
    logic [HourW-1:0] rtc_hours;
    logic [MinW-1:0]  rtc_minutes;
    logic [SecW-1:0]  rtc_seconds;
  } in_req_t;

  typedef struct packed {
    logic [HourW-1:0] cur_hours;
    logic [MinW-1:0]  cur_minutes;
    logic [SecW-1:0]  cur_seconds;
    logic             dots_lit;
    logic             in_setting;
    logic             write_time;
  } out_req_t;

endpackage

### rtl/core/ctsh_if.sv
`timescale 1ns / 1ps

// input request channel
interface ctsh_in_if
  import ctsh_pkg::*;
();
  logic             valid;
  logic             ready;
  logic             tick;
  logic             up_edge;
  logic             down_edge;
  logic             up_level;
  logic             down_level;
  logic             rtc_valid;
  logic [HourW-1:0] rtc_hours;
  logic [MinW-1:0]  rtc_minutes;
  logic [SecW-1:0]  rtc_seconds;

  modport source (
    output valid, tick, up_edge, down_edge, up_level, down_level,
           rtc_valid, rtc_hours, rtc_minutes, rtc_seconds,
    input  ready
  );
  modport sink (
    input  valid, tick, up_edge, down_edge, up_level, down_level,
           rtc_valid, rtc_hours, rtc_minutes, rtc_seconds,
    output ready
  );
endinterface

// result request channel
interface ctsh_out_if
  import ctsh_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [HourW-1:0] cur_hours;
  logic [MinW-1:0]  cur_minutes;
  logic [SecW-1:0]  cur_seconds;
  logic             dots_lit;
  logic             in_setting;
  logic             write_time;

  modport source (
    output valid, cur_hours, cur_minutes, cur_seconds, dots_lit,
           in_setting, write_time,
    input  ready
  );
  modport sink (
    input  valid, cur_hours, cur_minutes, cur_seconds, dots_lit,
           in_setting, write_time,
    output ready
  );
endinterface

### rtl/core/ctsh_cfg.sv
`timescale 1ns / 1ps

module ctsh_cfg
  import ctsh_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_idx,
  input  logic [CfgDataW-1:0] cfg_wdata,
  output cfg_t                cfg
);

  cfg_t cfg_r;

  // register file, writes beyond the list are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.debounce_ticks <= DebounceRst;
      cfg_r.medium_after   <= MediumRst;
      cfg_r.fast_after     <= FastRst;
      cfg_r.repeat_ticks   <= RepeatRst;
      cfg_r.fast_step      <= FstepRst;
      cfg_r.idle_exit      <= IdleRst;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_DEBOUNCE: cfg_r.debounce_ticks <= cfg_wdata[DebW-1:0];
        CFG_MEDIUM:   cfg_r.medium_after   <= cfg_wdata;
        CFG_FAST:     cfg_r.fast_after     <= cfg_wdata;
        CFG_REPEAT:   cfg_r.repeat_ticks   <= cfg_wdata;
        CFG_FSTEP:    cfg_r.fast_step      <= cfg_wdata[StepW-1:0];
        CFG_IDLE:     cfg_r.idle_exit      <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

### rtl/core/ctsh_time_step.sv
`timescale 1ns / 1ps

module ctsh_time_step
  import ctsh_pkg::*;
(
  input  logic [HourW-1:0]  hour,
  input  logic [MinW-1:0]   minute,
  input  logic [DeltaW-1:0] delta,
  input  logic              dir_down,
  output logic [HourW-1:0]  hour_out,
  output logic [MinW-1:0]   minute_out
);

  logic [7:0]        sum;
  logic signed [7:0] diff;
  logic [1:0]        carry;
  logic [5:0]        hsum;

  // minutes move by at most 64, so at most two hour carries or borrows
  always_comb begin
    sum        = {2'b00, minute} + {1'b0, delta};
    diff       = $signed({2'b00, minute}) - $signed({1'b0, delta});
    carry      = 2'd0;
    minute_out = minute;
    hsum       = {1'b0, hour};
    hour_out   = hour;
    if (!dir_down) begin
      if (sum >= 8'd120) begin
        minute_out = 6'(sum - 8'd120);
        carry      = 2'd2;
      end else if (sum >= 8'd60) begin
        minute_out = 6'(sum - 8'd60);
        carry      = 2'd1;
      end else begin
        minute_out = sum[MinW-1:0];
      end
      hsum = {1'b0, hour} + {4'b0000, carry};
      if (hsum >= 6'd24) begin
        hsum = hsum - 6'd24;
      end
    end else begin
      if (diff < -8'sd60) begin
        minute_out = 6'(diff + 8'sd120);
        carry      = 2'd2;
      end else if (diff < 8'sd0) begin
        minute_out = 6'(diff + 8'sd60);
        carry      = 2'd1;
      end else begin
        minute_out = diff[MinW-1:0];
      end
      if ({1'b0, hour} < {4'b0000, carry}) begin
        hsum = {1'b0, hour} + 6'd24 - {4'b0000, carry};
      end else begin
        hsum = {1'b0, hour} - {4'b0000, carry};
      end
    end
    hour_out = hsum[HourW-1:0];
  end

endmodule

### rtl/core/ctsh_ctrl.sv
`timescale 1ns / 1ps

module ctsh_ctrl
  import ctsh_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     adv,
  input  in_req_t  req,
  input  cfg_t     cfg,
  output out_req_t res
);

  localparam logic [DebW-1:0] DebSat = '1;
  localparam logic [CntW-1:0] CntSat = '1;

  logic [HourW-1:0] hour_r, hour_nxt;
  logic [MinW-1:0]  min_r, min_nxt;
  logic [SecW-1:0]  sec_r, sec_nxt;
  logic             dots_r, dots_nxt;
  logic             set_r, set_nxt;
  held_t            held_r, held_nxt;
  logic [CntW-1:0]  hold_r, hold_nxt;
  logic [CntW-1:0]  rep_r, rep_nxt;
  logic [CntW-1:0]  idle_r, idle_nxt;
  logic [DebW-1:0]  up_cnt_r, up_cnt_nxt;
  logic [DebW-1:0]  dn_cnt_r, dn_cnt_nxt;

  logic [DebW-1:0]   up_cnt1, dn_cnt1;
  logic [CntW-1:0]   hold1, rep1, idle1;
  logic              up_acc, dn_acc, up_step, dn_step, edge_step;
  logic              set_e, rep_fire, rep_step, wr;
  held_t             held1;
  logic [StepW-1:0]  amt;
  logic [DeltaW-1:0] delta;
  logic [HourW-1:0]  hour_st;
  logic [MinW-1:0]   min_st;

  ctsh_time_step u_step (
    .hour       (hour_r),
    .minute     (min_r),
    .delta      (delta),
    .dir_down   (held1 == HELD_DOWN),
    .hour_out   (hour_st),
    .minute_out (min_st)
  );

  // next state for one request
  always_comb begin
    // saturating counters advance on tick
    up_cnt1 = up_cnt_r;
    dn_cnt1 = dn_cnt_r;
    hold1   = hold_r;
    rep1    = rep_r;
    idle1   = idle_r;
    if (req.tick) begin
      if (up_cnt_r != DebSat) up_cnt1 = up_cnt_r + 1'b1;
      if (dn_cnt_r != DebSat) dn_cnt1 = dn_cnt_r + 1'b1;
      if (hold_r != CntSat)   hold1   = hold_r + 1'b1;
      if (rep_r != CntSat)    rep1    = rep_r + 1'b1;
      if (idle_r != CntSat)   idle1   = idle_r + 1'b1;
    end

    // debounced edges, up first
    up_acc    = req.up_edge && (up_cnt1 >= cfg.debounce_ticks);
    dn_acc    = req.down_edge && (dn_cnt1 >= cfg.debounce_ticks);
    up_step   = up_acc && (held_r == HELD_NONE);
    dn_step   = dn_acc && (held_r == HELD_NONE) && !up_step;
    edge_step = up_step || dn_step;
    set_e     = set_r || up_acc || dn_acc;
    held1     = up_step ? HELD_UP : (dn_step ? HELD_DOWN : held_r);

    up_cnt_nxt = up_acc ? '0 : up_cnt1;
    dn_cnt_nxt = dn_acc ? '0 : dn_cnt1;
    hold_nxt   = edge_step ? '0 : hold1;
    idle_nxt   = edge_step ? '0 : idle1;

    sec_nxt  = sec_r;
    dots_nxt = dots_r;
    if (!set_r && (up_acc || dn_acc)) begin
      sec_nxt  = '0;
      dots_nxt = 1'b1;
    end

    // hold repeat, step picked by hold time
    if (hold_nxt >= cfg.fast_after) begin
      amt = cfg.fast_step;
    end else if (hold_nxt >= cfg.medium_after) begin
      amt = StepW'(1);
    end else begin
      amt = '0;
    end
    rep_fire = set_e && (held1 != HELD_NONE) && (rep1 >= cfg.repeat_ticks);
    rep_step = rep_fire && (amt != '0);
    rep_nxt  = rep_fire ? '0 : rep1;
    if (rep_step) idle_nxt = '0;
    wr = edge_step || rep_step;

    // edge and repeat steps share one direction
    delta = DeltaW'({6'b0, edge_step}) + (rep_step ? {1'b0, amt} : '0);

    // clock chip load, or stepped time
    hour_nxt = hour_r;
    min_nxt  = min_r;
    if (!set_e && req.rtc_valid) begin
      hour_nxt = (req.rtc_hours > MaxHour) ? MaxHour : req.rtc_hours;
      min_nxt  = (req.rtc_minutes > MaxMin) ? MaxMin : req.rtc_minutes;
      sec_nxt  = (req.rtc_seconds > MaxSec) ? MaxSec : req.rtc_seconds;
      dots_nxt = !sec_nxt[0];
    end else if (wr) begin
      hour_nxt = hour_st;
      min_nxt  = min_st;
    end

    // idle exit
    set_nxt = set_e;
    if (set_e && (held1 == HELD_NONE) && (idle_nxt >= cfg.idle_exit)) begin
      set_nxt  = 1'b0;
      dots_nxt = 1'b1;
    end

    // button release
    held_nxt = held1;
    if (((held1 == HELD_UP) && req.up_level) ||
        ((held1 == HELD_DOWN) && req.down_level)) begin
      held_nxt = HELD_NONE;
      idle_nxt = '0;
    end

    res.cur_hours   = hour_nxt;
    res.cur_minutes = min_nxt;
    res.cur_seconds = sec_nxt;
    res.dots_lit    = dots_nxt;
    res.in_setting  = set_nxt;
    res.write_time  = wr;
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hour_r   <= '0;
      min_r    <= '0;
      sec_r    <= '0;
      dots_r   <= 1'b1;
      set_r    <= 1'b0;
      held_r   <= HELD_NONE;
      hold_r   <= '0;
      rep_r    <= '0;
      idle_r   <= '0;
      up_cnt_r <= DebSat;
      dn_cnt_r <= DebSat;
    end else if (adv) begin
      hour_r   <= hour_nxt;
      min_r    <= min_nxt;
      sec_r    <= sec_nxt;
      dots_r   <= dots_nxt;
      set_r    <= set_nxt;
      held_r   <= held_nxt;
      hold_r   <= hold_nxt;
      rep_r    <= rep_nxt;
      idle_r   <= idle_nxt;
      up_cnt_r <= up_cnt_nxt;
      dn_cnt_r <= dn_cnt_nxt;
    end
  end

endmodule

### rtl/core/clock_time_set_hold_repeat_core.sv
`timescale 1ns / 1ps
// path: input register, then the state update, then the result register
// throughput: one request per cycle while the result side is not stalled; the state
//   update is a single pass between the input register and the result register
// reset: synchronous active-low rst_n clears both valid stages, time to 00:00:00,
//   dots on, setting mode off, debounce counters saturated, config to defaults

module clock_time_set_hold_repeat_core
  import ctsh_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  ctsh_in_if.sink             in_ch,
  ctsh_out_if.source          out_ch,
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_idx,
  input  logic [CfgDataW-1:0] cfg_wdata
);

  cfg_t     cfg;
  in_req_t  in_r;
  logic     in_v_r;
  out_req_t res;
  out_req_t out_r;
  logic     out_v_r;
  logic     adv;

  ctsh_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  ctsh_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .adv   (adv),
    .req   (in_r),
    .cfg   (cfg),
    .res   (res)
  );

  // handshake: process when the result register is free or being drained
  assign adv         = in_v_r && (!out_v_r || out_ch.ready);
  assign in_ch.ready = !in_v_r || adv;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_v_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      in_r.tick        <= in_ch.tick;
      in_r.up_edge     <= in_ch.up_edge;
      in_r.down_edge   <= in_ch.down_edge;
      in_r.up_level    <= in_ch.up_level;
      in_r.down_level  <= in_ch.down_level;
      in_r.rtc_valid   <= in_ch.rtc_valid;
      in_r.rtc_hours   <= in_ch.rtc_hours;
      in_r.rtc_minutes <= in_ch.rtc_minutes;
      in_r.rtc_seconds <= in_ch.rtc_seconds;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (adv) begin
      out_v_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_r <= res;
    end
  end

  assign out_ch.valid       = out_v_r;
  assign out_ch.cur_hours   = out_r.cur_hours;
  assign out_ch.cur_minutes = out_r.cur_minutes;
  assign out_ch.cur_seconds = out_r.cur_seconds;
  assign out_ch.dots_lit    = out_r.dots_lit;
  assign out_ch.in_setting  = out_r.in_setting;
  assign out_ch.write_time  = out_r.write_time;

endmodule

### rtl/core/ctsh_checker.sv
`timescale 1ns / 1ps

module ctsh_checker
  import ctsh_pkg::*;
(
  input logic             clk,
  input logic             rst_n,
  input logic             out_valid,
  input logic             out_ready,
  input logic [HourW-1:0] cur_hours,
  input logic [MinW-1:0]  cur_minutes,
  input logic [SecW-1:0]  cur_seconds,
  input logic             dots_lit,
  input logic             in_setting,
  input logic             write_time
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(cur_hours) &&
      $stable(cur_minutes) && $stable(cur_seconds) && $stable(write_time)))
    else $error("stalled result changed");

  // time always in range
  a_time_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (cur_hours <= MaxHour && cur_minutes <= MaxMin &&
      cur_seconds <= MaxSec))
    else $error("time out of range");

  // a chip write only comes from setting mode
  a_write_setting: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && write_time) |-> in_setting)
    else $error("write outside setting mode");

  // dots forced on while setting
  a_dots_setting: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && in_setting) |-> dots_lit)
    else $error("dots off in setting mode");

endmodule

bind clock_time_set_hold_repeat_core ctsh_checker u_ctsh_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .cur_hours   (out_ch.cur_hours),
  .cur_minutes (out_ch.cur_minutes),
  .cur_seconds (out_ch.cur_seconds),
  .dots_lit    (out_ch.dots_lit),
  .in_setting  (out_ch.in_setting),
  .write_time  (out_ch.write_time)
);

### tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import ctsh_pkg::*;

  localparam int QuietLimit = 3000;
  localparam int LatencyPad = 6;

  logic clk;
  logic rst_n;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_idx;
  logic [CfgDataW-1:0] cfg_wdata;

  ctsh_in_if  in_bus ();
  ctsh_out_if out_bus ();

  clock_time_set_hold_repeat_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_bus),
    .out_ch    (out_bus),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  // 10 ns clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // predicted clock state
  logic [HourW-1:0] hour_now;
  logic [MinW-1:0]  minute_now;
  logic [SecW-1:0]  second_now;
  logic             dots_now;
  logic             setting_now;
  held_t            held_now;
  logic [CntW-1:0]  hold_age;
  logic [CntW-1:0]  repeat_age;
  logic [CntW-1:0]  idle_age;
  logic [DebW-1:0]  up_age;
  logic [DebW-1:0]  down_age;

  // predicted register values
  logic [DebW-1:0]  debounce_cfg;
  logic [CntW-1:0]  medium_cfg;
  logic [CntW-1:0]  fast_cfg;
  logic [CntW-1:0]  repeat_cfg;
  logic [StepW-1:0] fstep_cfg;
  logic [CntW-1:0]  idle_cfg;

  out_req_t expected_display_q[$];
  int       fail_count;
  int       quiet_cycles;
  int       hold_off_left;
  bit       source_steady;
  bit       sink_steady;

  // ---------------- predictor ----------------

  function automatic void clear_clock_state();
    hour_now    = '0;
    minute_now  = '0;
    second_now  = '0;
    dots_now    = 1'b1;
    setting_now = 1'b0;
    held_now    = HELD_NONE;
    hold_age    = '0;
    repeat_age  = '0;
    idle_age    = '0;
    up_age      = '1;
    down_age    = '1;
    debounce_cfg = DebounceRst;
    medium_cfg   = MediumRst;
    fast_cfg     = FastRst;
    repeat_cfg   = RepeatRst;
    fstep_cfg    = FstepRst;
    idle_cfg     = IdleRst;
  endfunction

  function automatic void add_minutes(input int unsigned amt);
    int unsigned m;
    m = minute_now + amt;
    while (m >= 60) begin
      m = m - 60;
      hour_now = (hour_now >= MaxHour) ? '0 : hour_now + 1'b1;
    end
    minute_now = MinW'(m);
  endfunction

  function automatic void sub_minutes(input int unsigned amt);
    for (int unsigned i = 0; i < amt; i++) begin
      if (minute_now == 0) begin
        minute_now = MaxMin;
        hour_now = (hour_now == 0) ? MaxHour : hour_now - 1'b1;
      end else begin
        minute_now = minute_now - 1'b1;
      end
    end
  endfunction

  // returns 1 when the press stepped the time
  function automatic bit take_press(input held_t which);
    if (!setting_now) begin
      setting_now = 1'b1;
      second_now  = '0;
      dots_now    = 1'b1;
    end
    if (held_now != HELD_NONE) return 1'b0;
    held_now = which;
    hold_age = '0;
    idle_age = '0;
    if (which == HELD_UP) add_minutes(1);
    else sub_minutes(1);
    return 1'b1;
  endfunction

  function automatic out_req_t next_display(input in_req_t r);
    out_req_t    o;
    logic        changed;
    int unsigned step;
    changed = 1'b0;
    step    = 0;
    // saturating counters
    if (r.tick) begin
      if (up_age != '1)     up_age     = up_age + 1'b1;
      if (down_age != '1)   down_age   = down_age + 1'b1;
      if (hold_age != '1)   hold_age   = hold_age + 1'b1;
      if (repeat_age != '1) repeat_age = repeat_age + 1'b1;
      if (idle_age != '1)   idle_age   = idle_age + 1'b1;
    end
    // debounced edges, up first
    if (r.up_edge && up_age >= debounce_cfg) begin
      up_age = '0;
      if (take_press(HELD_UP)) changed = 1'b1;
    end
    if (r.down_edge && down_age >= debounce_cfg) begin
      down_age = '0;
      if (take_press(HELD_DOWN)) changed = 1'b1;
    end
    // clock chip reading, clamped
    if (!setting_now && r.rtc_valid) begin
      hour_now   = (r.rtc_hours > MaxHour) ? MaxHour : r.rtc_hours;
      minute_now = (r.rtc_minutes > MaxMin) ? MaxMin : r.rtc_minutes;
      second_now = (r.rtc_seconds > MaxSec) ? MaxSec : r.rtc_seconds;
      dots_now   = ~second_now[0];
    end
    // hold repeat
    if (setting_now && held_now != HELD_NONE) begin
      if (hold_age >= fast_cfg) step = int'(fstep_cfg);
      else if (hold_age >= medium_cfg) step = 1;
      if (repeat_age >= repeat_cfg) begin
        if (step > 0) begin
          if (held_now == HELD_UP) add_minutes(step);
          else sub_minutes(step);
          changed  = 1'b1;
          idle_age = '0;
        end
        repeat_age = '0;
      end
    end
    // idle exit
    if (setting_now && held_now == HELD_NONE && idle_age >= idle_cfg) begin
      setting_now = 1'b0;
      dots_now    = 1'b1;
    end
    // release
    if ((held_now == HELD_UP && r.up_level) ||
        (held_now == HELD_DOWN && r.down_level)) begin
      held_now = HELD_NONE;
      idle_age = '0;
    end
    o.cur_hours   = hour_now;
    o.cur_minutes = minute_now;
    o.cur_seconds = second_now;
    o.dots_lit    = dots_now;
    o.in_setting  = setting_now;
    o.write_time  = changed;
    return o;
  endfunction

  // ---------------- result checking ----------------

  task automatic report_failure(input string what, input out_req_t want,
                                input out_req_t got);
    string want_s;
    string got_s;
    fail_count++;
    if (fail_count <= 10) begin
      want_s = $sformatf("%0d:%0d:%0d dots %0b set %0b wr %0b", want.cur_hours,
                         want.cur_minutes, want.cur_seconds, want.dots_lit,
                         want.in_setting, want.write_time);
      got_s  = $sformatf("%0d:%0d:%0d dots %0b set %0b wr %0b", got.cur_hours,
                         got.cur_minutes, got.cur_seconds, got.dots_lit,
                         got.in_setting, got.write_time);
      $display("%0t %s: want %s, got %s", $realtime, what, want_s, got_s);
    end
  endtask

  always @(posedge clk) begin
    out_req_t got;
    out_req_t want;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      got.cur_hours   = out_bus.cur_hours;
      got.cur_minutes = out_bus.cur_minutes;
      got.cur_seconds = out_bus.cur_seconds;
      got.dots_lit    = out_bus.dots_lit;
      got.in_setting  = out_bus.in_setting;
      got.write_time  = out_bus.write_time;
      if (expected_display_q.size() == 0) begin
        report_failure("unexpected result", got, got);
      end else begin
        want = expected_display_q.pop_front();
        if (got.cur_hours !== want.cur_hours || got.cur_minutes !== want.cur_minutes ||
            got.cur_seconds !== want.cur_seconds || got.dots_lit !== want.dots_lit ||
            got.in_setting !== want.in_setting || got.write_time !== want.write_time)
          report_failure("mismatch", want, got);
      end
    end
  end

  // watchdog on cycles with no handshake on either side
  always @(posedge clk) begin
    if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QuietLimit) begin
      $display("timeout after %0d quiet cycles", quiet_cycles);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // gap length: mostly short, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 2);
    if (r < 95) return $urandom_range(3, 10);
    return $urandom_range(20, 60);
  endfunction

  // result side ready, random stalls plus requested hold-off
  initial begin
    int stall_left;
    stall_left = 0;
    out_bus.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_left > 0) begin
        out_bus.ready = 1'b0;
        hold_off_left = hold_off_left - 1;
      end else if (stall_left > 0) begin
        out_bus.ready = 1'b0;
        stall_left--;
      end else if (!sink_steady && $urandom_range(0, 99) < 20) begin
        out_bus.ready = 1'b0;
        stall_left = pick_gap() - 1;
      end else begin
        out_bus.ready = 1'b1;
      end
    end
  end

  // ---------------- stimulus helpers ----------------

  task automatic send_request(input in_req_t r);
    int gap;
    gap = 0;
    if (!source_steady && $urandom_range(0, 99) < 25) gap = pick_gap();
    if (gap > 0) begin
      in_bus.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_bus.tick        = r.tick;
    in_bus.up_edge     = r.up_edge;
    in_bus.down_edge   = r.down_edge;
    in_bus.up_level    = r.up_level;
    in_bus.down_level  = r.down_level;
    in_bus.rtc_valid   = r.rtc_valid;
    in_bus.rtc_hours   = r.rtc_hours;
    in_bus.rtc_minutes = r.rtc_minutes;
    in_bus.rtc_seconds = r.rtc_seconds;
    in_bus.valid       = 1'b1;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    expected_display_q.push_back(next_display(r));
    @(negedge clk);
    in_bus.valid = 1'b0;
  endtask

  function automatic in_req_t make_request(input bit tick, input bit ue, input bit de,
                                           input bit ul, input bit dl, input bit rv,
                                           input int h, input int m, input int s);
    in_req_t r;
    r.tick        = tick;
    r.up_edge     = ue;
    r.down_edge   = de;
    r.up_level    = ul;
    r.down_level  = dl;
    r.rtc_valid   = rv;
    r.rtc_hours   = HourW'(h);
    r.rtc_minutes = MinW'(m);
    r.rtc_seconds = SecW'(s);
    return r;
  endfunction

  // random in-range reading, present now and then
  function automatic in_req_t button_request(input bit ue, input bit de, input bit ul,
                                             input bit dl);
    return make_request($urandom_range(0, 7) != 0, ue, de, ul, dl,
                        $urandom_range(0, 9) == 0, $urandom_range(0, 23),
                        $urandom_range(0, 59), $urandom_range(0, 59));
  endfunction

  // sender pauses until every result is back, then lets the pipe settle
  task automatic wait_drained();
    in_bus.valid = 1'b0;
    while (expected_display_q.size() != 0) @(negedge clk);
    repeat (LatencyPad) @(negedge clk);
  endtask

  task automatic write_register(input cfg_idx_t idx, input int unsigned value);
    cfg_we    = 1'b1;
    cfg_idx   = idx;
    cfg_wdata = CfgDataW'(value);
    case (idx)
      CFG_DEBOUNCE: debounce_cfg = DebW'(value);
      CFG_MEDIUM:   medium_cfg   = CntW'(value);
      CFG_FAST:     fast_cfg     = CntW'(value);
      CFG_REPEAT:   repeat_cfg   = CntW'(value);
      CFG_FSTEP:    fstep_cfg    = StepW'(value);
      CFG_IDLE:     idle_cfg     = CntW'(value);
      default: ;
    endcase
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic apply_settings(input int unsigned deb, input int unsigned med,
                                input int unsigned fast, input int unsigned rep,
                                input int unsigned fstep, input int unsigned idle);
    wait_drained();
    write_register(CFG_DEBOUNCE, deb);
    write_register(CFG_MEDIUM, med);
    write_register(CFG_FAST, fast);
    write_register(CFG_REPEAT, rep);
    write_register(CFG_FSTEP, fstep);
    write_register(CFG_IDLE, idle);
  endtask

  // mostly press, hold, release sequences; some readings and noise
  task automatic run_random(input int count);
    int    sent;
    int    kind;
    int    hold_len;
    held_t which;
    bit    up_side;
    sent = 0;
    while (sent < count) begin
      source_steady = ($urandom_range(0, 9) == 0);
      sink_steady   = ($urandom_range(0, 9) == 0);
      kind = $urandom_range(0, 99);
      if (kind < 75) begin
        up_side = 1'($urandom_range(0, 1));
        which   = up_side ? HELD_UP : HELD_DOWN;
        // a few idle ticks before the press
        repeat ($urandom_range(0, 4)) begin
          send_request(button_request(1'b0, 1'b0, 1'b1, 1'b1));
          sent++;
        end
        send_request(button_request(up_side, !up_side, !up_side, up_side));
        sent++;
        hold_len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 60)
                                               : $urandom_range(0, 12);
        repeat (hold_len) begin
          send_request(button_request($urandom_range(0, 19) == 0, $urandom_range(0, 19) == 0,
                                      !up_side, up_side));
          sent++;
        end
        // release
        send_request(button_request(1'b0, 1'b0, 1'b1, 1'b1));
        sent++;
      end else if (kind < 90) begin
        send_request(make_request(1'($urandom_range(0, 1)), 1'b0, 1'b0, 1'b1, 1'b1, 1'b1,
                                  $urandom_range(0, 23), $urandom_range(0, 59),
                                  $urandom_range(0, 59)));
        sent++;
      end else begin
        send_request(make_request(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                                  1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                                  1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                                  $urandom_range(0, 23), $urandom_range(0, 59),
                                  $urandom_range(0, 59)));
        sent++;
      end
    end
    source_steady = 1'b0;
    sink_steady   = 1'b0;
  endtask

  // ---------------- tests ----------------

  // clock chip readings outside setting mode, clamping and dot parity
  task automatic test_clock_chip_load();
    send_request(make_request(1, 0, 0, 1, 1, 1, 23, 59, 59));
    send_request(make_request(1, 0, 0, 1, 1, 1, 0, 0, 0));
    send_request(make_request(0, 0, 0, 1, 1, 1, 31, 63, 63));
    send_request(make_request(1, 0, 0, 1, 1, 1, 24, 60, 60));
    send_request(make_request(1, 0, 0, 1, 1, 0, 31, 63, 63));
    send_request(make_request(0, 0, 0, 1, 1, 1, 15, 42, 21));
  endtask

  // both edges at once, edge while held, reading ignored, debounce reject
  task automatic test_button_press();
    send_request(make_request(0, 1, 1, 0, 0, 0, 0, 0, 0));
    send_request(make_request(1, 0, 0, 0, 0, 1, 8, 16, 32));
    send_request(make_request(1, 1, 0, 0, 1, 0, 0, 0, 0));
    send_request(make_request(1, 0, 0, 1, 1, 0, 0, 0, 0));
    send_request(make_request(1, 0, 1, 1, 0, 0, 0, 0, 0));
    send_request(make_request(1, 0, 0, 1, 1, 0, 0, 0, 0));
  endtask

  // zero thresholds, fast step of 59, hour wrap both ways
  task automatic test_low_thresholds();
    apply_settings(0, 0, 2, 1, 59, 0);
    send_request(make_request(1, 0, 0, 1, 1, 0, 0, 0, 0));
    send_request(make_request(1, 0, 0, 1, 1, 1, 0, 0, 1));
    send_request(make_request(0, 0, 1, 1, 0, 0, 0, 0, 0));
    repeat (4) send_request(make_request(1, 0, 0, 1, 0, 0, 0, 0, 0));
    send_request(make_request(1, 0, 0, 1, 1, 0, 0, 0, 0));
    send_request(make_request(1, 0, 0, 1, 1, 1, 23, 59, 30));
    send_request(make_request(1, 1, 0, 0, 1, 0, 0, 0, 0));
    repeat (3) send_request(make_request(1, 0, 0, 0, 1, 0, 0, 0, 0));
    send_request(make_request(1, 0, 0, 1, 1, 0, 0, 0, 0));
  endtask

  // largest thresholds, smallest fast step
  task automatic test_high_thresholds();
    apply_settings(255, 65535, 65535, 65535, 1, 65535);
    send_request(make_request(1, 1, 0, 0, 1, 0, 0, 0, 0));
    send_request(make_request(1, 0, 1, 1, 0, 0, 0, 0, 0));
    send_request(make_request(1, 0, 0, 1, 1, 1, 12, 0, 0));
  endtask

  // long receiver hold-off with the sender pushing, then a full drain
  task automatic test_backpressure();
    apply_settings(3, 5, 15, 2, 7, 40);
    source_steady = 1'b1;
    hold_off_left = 150;
    repeat (40) send_request(button_request(1'($urandom_range(0, 1)),
                                            1'($urandom_range(0, 1)),
                                            1'($urandom_range(0, 1)),
                                            1'($urandom_range(0, 1))));
    source_steady = 1'b0;
    wait_drained();
    run_random(30);
  endtask

  task automatic test_random_settings();
    apply_settings(3, 5, 15, 2, 7, 40);
    run_random(320);
    apply_settings($urandom_range(0, 6), $urandom_range(0, 10), $urandom_range(0, 30),
                   $urandom_range(1, 5), $urandom_range(1, 59), $urandom_range(0, 60));
    run_random(320);
    apply_settings(0, 0, 0, 1, 59, 0);
    run_random(320);
    apply_settings(20, 3, 8, 3, 1, 300);
    run_random(320);
    apply_settings(255, 65535, 65535, 65535, 59, 65535);
    run_random(250);
  endtask

  // ---------------- main sequence ----------------

  initial begin
    fail_count     = 0;
    hold_off_left  = 0;
    source_steady  = 1'b0;
    sink_steady    = 1'b0;
    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_idx        = CFG_DEBOUNCE;
    cfg_wdata      = '0;
    in_bus.valid       = 1'b0;
    in_bus.tick        = 1'b0;
    in_bus.up_edge     = 1'b0;
    in_bus.down_edge   = 1'b0;
    in_bus.up_level    = 1'b1;
    in_bus.down_level  = 1'b1;
    in_bus.rtc_valid   = 1'b0;
    in_bus.rtc_hours   = '0;
    in_bus.rtc_minutes = '0;
    in_bus.rtc_seconds = '0;
    clear_clock_state();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_clock_chip_load();
    test_button_press();
    test_low_thresholds();
    test_high_thresholds();
    test_backpressure();
    test_random_settings();

    wait_drained();
    repeat (8) @(posedge clk);
    if (fail_count == 0 && expected_display_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
